### hw/rtl/ich_pkg.sv
// types, codes and constants shared by the channel histogram files
package ich_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned BIN_COUNT       = 256;
  localparam int unsigned BIN_W           = 8;
  localparam int unsigned CHANNELS        = 4;
  localparam int unsigned CH_W            = 2;
  localparam int unsigned OUT_W           = 32;
  localparam int unsigned CMD_DEPTH       = 4;
  localparam int unsigned RES_DEPTH       = 2;

  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CH_W-1:0] CH_LUMA = 2'd0;
  localparam logic [CH_W-1:0] CH_RED  = 2'd1;
  localparam logic [CH_W-1:0] CH_GRN  = 2'd2;
  localparam logic [CH_W-1:0] CH_BLU  = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [BIN_W-1:0] gray_level;
    logic [BIN_W-1:0] red;
    logic [BIN_W-1:0] green;
    logic [BIN_W-1:0] blue;
    logic [CH_W-1:0]  read_channel;
    logic [BIN_W-1:0] read_bin;
  } ich_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] channel_peak;
    logic             has_data;
  } ich_out_t;

  // decoded command between front and back
  typedef struct packed {
    logic [1:0]                     kind;
    logic [CHANNELS-1:0]            lane_en;
    logic [CHANNELS-1:0][BIN_W-1:0] addr;
    logic [CH_W-1:0]                rd_ch;
  } ich_cmd_t;

endpackage

### hw/rtl/ich_fifo.sv
// small register queue used for commands and results
module ich_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  // depth is a power of two so the pointers wrap on their own
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/ich_front.sv
// input side: mode register, luma computation and command decode
module ich_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i,
  input  logic             push,
  output logic             full,
  input  ich_pkg::ich_in_t in_word_i,
  input  logic             busy_i,
  output logic             cmd_push_o,
  output ich_pkg::ich_cmd_t cmd_o,
  input  logic             cmd_full_i
);
  import ich_pkg::*;

  logic        color_q;
  logic [12:0] lum_sum;
  logic [BIN_W-1:0] lum;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full_i || busy_i;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b0;
    end else if (cfg_valid_i) begin
      color_q <= cfg_data_i;
    end
  end

  // weighted sum, max 255*32 fits 13 bits
  assign lum_sum = 13'(in_word_i.red) * 13'd11 + 13'(in_word_i.green) * 13'd16
                 + 13'(in_word_i.blue) * 13'd5;
  assign lum     = lum_sum[12:5];

  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = in_word_i.opcode;
    cmd_o.rd_ch = in_word_i.read_channel;
    cmd_push_o  = 1'b0;
    case (in_word_i.opcode)
      OP_ACCUM: begin
        cmd_push_o = accept;
        if (color_q) begin
          cmd_o.lane_en       = '1;
          cmd_o.addr[CH_LUMA] = lum;
          cmd_o.addr[CH_RED]  = in_word_i.red;
          cmd_o.addr[CH_GRN]  = in_word_i.green;
          cmd_o.addr[CH_BLU]  = in_word_i.blue;
        end else begin
          cmd_o.lane_en[CH_LUMA] = 1'b1;
          cmd_o.addr[CH_LUMA]    = in_word_i.gray_level;
        end
      end
      OP_CLEAR: begin
        cmd_push_o = accept;
      end
      OP_READ: begin
        cmd_push_o = accept;
        for (int b = 0; b < CHANNELS; b++) begin
          cmd_o.addr[b] = in_word_i.read_bin;
        end
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/ich_back.sv
// execution side: bin banks, peaks, clear sweep and read results
module ich_back #(
  parameter int unsigned COUNT_WIDTH = ich_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ich_pkg::ich_cmd_t cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output logic              res_push_o,
  output ich_pkg::ich_out_t res_o,
  input  logic              res_full_i,
  output logic              busy_o
);
  import ich_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0]             state_q, state_d;
  ich_cmd_t               cmd_q;
  logic [BIN_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   seen_q, seen_d;
  logic [COUNT_WIDTH-1:0] peak_q [CHANNELS];
  logic [COUNT_WIDTH-1:0] peak_d [CHANNELS];
  logic [COUNT_WIDTH-1:0] rdata_q [CHANNELS];
  logic [COUNT_WIDTH-1:0] inc [CHANNELS];
  logic [COUNT_WIDTH-1:0] wdata [CHANNELS];
  logic [BIN_W-1:0]       waddr [CHANNELS];
  logic [CHANNELS-1:0]    we;
  logic                   rd_en;
  logic [COUNT_WIDTH+OUT_W-1:0] ext_bin, ext_peak;

  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;
  assign rd_en     = (state_q == S_READ);
  assign busy_o    = busy_q;

  // output clip to 32 bits for wide counters
  assign ext_bin  = {{OUT_W{1'b0}}, rdata_q[cmd_q.rd_ch]};
  assign ext_peak = {{OUT_W{1'b0}}, peak_q[cmd_q.rd_ch]};
  always_comb begin
    res_o.bin_count    = (|ext_bin[COUNT_WIDTH+OUT_W-1:OUT_W]) ? '1 : ext_bin[OUT_W-1:0];
    res_o.channel_peak = (|ext_peak[COUNT_WIDTH+OUT_W-1:OUT_W]) ? '1 : ext_peak[OUT_W-1:0];
    res_o.has_data     = seen_q;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    busy_d     = busy_q;
    seen_d     = seen_q;
    res_push_o = 1'b0;
    we         = '0;
    for (int b = 0; b < CHANNELS; b++) begin
      inc[b]    = (rdata_q[b] == '1) ? rdata_q[b] : rdata_q[b] + COUNT_WIDTH'(1);
      peak_d[b] = peak_q[b];
      wdata[b]  = inc[b];
      waddr[b]  = cmd_q.addr[b];
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          state_d = (cmd_i.kind == OP_CLEAR) ? S_CLEAR : S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_q.kind == OP_READ) begin
          res_push_o = !res_full_i;
          if (!res_full_i) begin
            state_d = S_IDLE;
          end
        end else begin
          // read-modify-write on each enabled lane
          we     = cmd_q.lane_en;
          seen_d = 1'b1;
          for (int b = 0; b < CHANNELS; b++) begin
            if (cmd_q.lane_en[b] && (inc[b] > peak_q[b])) begin
              peak_d[b] = inc[b];
            end
          end
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        we     = '1;
        seen_d = 1'b0;
        cnt_d  = cnt_q + BIN_W'(1);
        for (int b = 0; b < CHANNELS; b++) begin
          peak_d[b] = '0;
          wdata[b]  = '0;
          waddr[b]  = cnt_q;
        end
        if (cnt_q == BIN_W'(BIN_COUNT - 1)) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      busy_q  <= 1'b1;
      seen_q  <= 1'b0;
      for (int b = 0; b < CHANNELS; b++) begin
        peak_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      seen_q  <= seen_d;
      for (int b = 0; b < CHANNELS; b++) begin
        peak_q[b] <= peak_d[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  // one bank per channel, one write and one registered read port each
  for (genvar g = 0; g < CHANNELS; g++) begin : g_bank
    logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
    always_ff @(posedge clk_i) begin
      if (we[g]) begin
        mem[waddr[g]] <= wdata[g];
      end
      if (rd_en) begin
        rdata_q[g] <= mem[cmd_q.addr[g]];
      end
    end
  end

  a_no_pop_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !cmd_pop_o)
    else $error("command taken during clear sweep");

  a_clear_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_CLEAR && state_q == S_IDLE) |->
      (peak_q[0] == '0 && peak_q[3] == '0 && !seen_q))
    else $error("peaks or flag left set after clear");

  a_peak_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (peak_q[0] >= $past(peak_q[0])
                             && peak_q[1] >= $past(peak_q[1])))
    else $error("peak dropped outside clear");

  a_res_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (!res_full_i && cmd_q.kind == OP_READ))
    else $error("result pushed into full queue or for non-read");

endmodule

### hw/rtl/image_channel_histogram.sv
// top level of the four-channel pixel histogram
// back end: one word at a time; an accumulate or read word is popped, read from the
//   banks, then written back (a read pushes its result instead, waiting while the
//   result queue is full), for the read-modify-write on the bins; a clear sweeps all bins
// reset: asynchronous active low; afterwards a clearing pass sweeps all banks while full
//   stays high; configuration writes are taken during it
module image_channel_histogram #(
  parameter int unsigned COUNT_WIDTH = ich_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: color_mode
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  // input queue side
  input  logic              push,
  output logic              full,
  input  ich_pkg::ich_in_t  in_word_i,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output ich_pkg::ich_out_t out_word_o
);
  import ich_pkg::*;

  ich_cmd_t cmd_in, cmd_head;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic     busy;
  ich_out_t res;
  logic     res_push, res_full;

  // front: decode words, compute luma bin, hold the mode bit
  ich_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .busy_i      (busy),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  // command queue decouples front and back
  ich_fifo #(
    .WIDTH ($bits(ich_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  // back: bank updates, peaks, clear sweep and read results
  ich_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full),
    .busy_o      (busy)
  );

  // result queue, lets the back end run while results wait
  ich_fifo #(
    .WIDTH ($bits(ich_out_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

endmodule

### test/image_channel_histogram_test.sv
// self-checking testbench for the four-channel pixel histogram
`timescale 1ns / 100ps

module image_channel_histogram_test;
  import ich_pkg::*;

  // opcode 3 has no meaning, the block drops it
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int unsigned CW = COUNT_WIDTH_DEF;
  localparam logic [63:0] CNT_MAX = (CW >= 64) ? '1 : (64'd1 << CW) - 64'd1;

  // a clear sweeps every bin, so allow a full command queue of clears plus two more
  localparam int SETTLE_CYCLES   = (CMD_DEPTH + 2) * (BIN_COUNT + 4);
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int WORDS_PER_PHASE = 150;

  // per random phase: sender idle percent, receiver stall percent, color mode
  localparam int SEND_IDLE [4] = '{0, 71, 0, 25};
  localparam int POP_STALL [4] = '{0, 0, 71, 25};
  localparam bit PHASE_MODE [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

  // pixel values that come back often, so bins pile up and peaks move
  localparam logic [7:0] PALETTE [8] = '{8'd0, 8'd1, 8'd64, 8'd127, 8'd128, 8'd200, 8'd254,
                                         8'd255};

  typedef enum logic {ROW_WORD, ROW_MODE} row_kind_e;

  typedef struct {
    row_kind_e kind;
    bit        mode;
    ich_in_t   w;
    bit        fixed;
    ich_out_t  want;
  } plan_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic     cfg_data_i  = 1'b0;
  logic     push        = 1'b0;
  logic     full;
  ich_in_t  in_word     = '0;
  logic     empty;
  logic     pop         = 1'b0;
  ich_out_t out_word;

  // expectation attached to the word on the input port (directed rows only)
  bit       drv_fixed = 1'b0;
  ich_out_t drv_want  = '0;

  // histogram predictor state
  logic [63:0] bin_tally [CHANNELS*BIN_COUNT];
  logic [63:0] peak_tally [CHANNELS];
  bit          pixels_seen;
  bit          mode_q;

  ich_out_t  read_queue [$];
  plan_row_t plan [$];
  logic [7:0] hot_bin [CHANNELS];

  int errors        = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  image_channel_histogram #(
    .COUNT_WIDTH(CW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void wipe_histogram();
    foreach (bin_tally[i]) bin_tally[i] = '0;
    foreach (peak_tally[i]) peak_tally[i] = '0;
    pixels_seen = 1'b0;
  endfunction

  // saturating increment of one bin, then peak tracking for its channel
  function automatic void count_bin(logic [CH_W-1:0] ch, logic [7:0] bin);
    logic [63:0] v;
    v = bin_tally[{ch, bin}];
    if (v < CNT_MAX) v = v + 64'd1;
    bin_tally[{ch, bin}] = v;
    if (v > peak_tally[ch]) peak_tally[ch] = v;
  endfunction

  function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned lum;
    lum = (32'(r) * 11 + 32'(g) * 16 + 32'(b) * 5) / 32;
    return lum[7:0];
  endfunction

  // counts clip to the 32-bit output field
  function automatic logic [OUT_W-1:0] clip(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[OUT_W-1:0];
  endfunction

  // apply one accepted word; a read queues what the block should answer
  function automatic void tally_word(ich_in_t w, bit fixed, ich_out_t want);
    ich_out_t pred;
    case (w.opcode)
      OP_ACCUM: begin
        if (mode_q) begin
          count_bin(CH_LUMA, luma_of(w.red, w.green, w.blue));
          count_bin(CH_RED, w.red);
          count_bin(CH_GRN, w.green);
          count_bin(CH_BLU, w.blue);
        end else begin
          count_bin(CH_LUMA, w.gray_level);
        end
        pixels_seen = 1'b1;
      end
      OP_CLEAR: wipe_histogram();
      OP_READ: begin
        pred.bin_count    = clip(bin_tally[{w.read_channel, w.read_bin}]);
        pred.channel_peak = clip(peak_tally[w.read_channel]);
        pred.has_data     = pixels_seen;
        read_queue.push_back(fixed ? want : pred);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_read(ich_out_t got);
    ich_out_t want;
    if (read_queue.size() == 0) begin
      $display("%0t: unexpected word, expected none, got count %0d peak %0d data %0b",
               $time, got.bin_count, got.channel_peak, got.has_data);
      errors++;
      return;
    end
    want = read_queue.pop_front();
    check_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
    check_field("channel_peak", 64'(want.channel_peak), 64'(got.channel_peak));
    check_field("has_data", 64'(want.has_data), 64'(got.has_data));
  endfunction

  // sample every handshake at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) mode_q = cfg_data_i;
      if (push && !full) tally_word(in_word, drv_fixed, drv_want);
      if (pop && !empty) check_read(out_word);
    end
  end

  // watchdog: too long without any accepted word, result pop or mode write means the block hung
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver side stalls at the phase's rate
  always @(negedge clk_i) pop <= ($urandom_range(99) >= pop_stall_pct);

  // ---------------------------------------------------------------- stimulus

  function automatic ich_in_t noisy();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(ich_in_t)-1:0];
  endfunction

  function automatic ich_in_t px_grey(logic [7:0] g);
    ich_in_t w;
    w = noisy();
    w.opcode     = OP_ACCUM;
    w.gray_level = g;
    return w;
  endfunction

  function automatic ich_in_t px_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    ich_in_t w;
    w = noisy();
    w.opcode = OP_ACCUM;
    w.red    = r;
    w.green  = g;
    w.blue   = b;
    return w;
  endfunction

  function automatic ich_in_t rd_bin(logic [CH_W-1:0] ch, logic [7:0] bin);
    ich_in_t w;
    w = noisy();
    w.opcode       = OP_READ;
    w.read_channel = ch;
    w.read_bin     = bin;
    return w;
  endfunction

  function automatic ich_in_t bare(logic [1:0] op);
    ich_in_t w;
    w = noisy();
    w.opcode = op;
    return w;
  endfunction

  function automatic ich_out_t res(int unsigned bc, int unsigned pk, bit hd);
    ich_out_t r;
    r.bin_count    = bc;
    r.channel_peak = pk;
    r.has_data     = hd;
    return r;
  endfunction

  function automatic plan_row_t word_row(ich_in_t w);
    return '{kind: ROW_WORD, mode: 1'b0, w: w, fixed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t check_row(ich_in_t w, ich_out_t want);
    return '{kind: ROW_WORD, mode: 1'b0, w: w, fixed: 1'b1, want: want};
  endfunction

  function automatic plan_row_t mode_row(bit m);
    return '{kind: ROW_MODE, mode: m, w: '0, fixed: 1'b0, want: '0};
  endfunction

  function automatic logic [7:0] hue();
    return ($urandom_range(9) < 7) ? PALETTE[$urandom_range(7)] : 8'($urandom);
  endfunction

  // random word: mostly pixels and reads, half of the reads of bins that were just hit
  function automatic ich_in_t next_word();
    ich_in_t w;
    int unsigned pick;
    w    = noisy();
    pick = $urandom_range(99);
    if (pick < 58) begin
      w.opcode     = OP_ACCUM;
      w.gray_level = hue();
      w.red        = hue();
      w.green      = hue();
      w.blue       = hue();
      hot_bin[CH_LUMA] = mode_q ? luma_of(w.red, w.green, w.blue) : w.gray_level;
      hot_bin[CH_RED]  = w.red;
      hot_bin[CH_GRN]  = w.green;
      hot_bin[CH_BLU]  = w.blue;
    end else if (pick < 93) begin
      w.opcode = OP_READ;
      if ($urandom_range(1) == 1) w.read_bin = hot_bin[w.read_channel];
    end else if (pick < 95) begin
      w.opcode = OP_CLEAR;
    end else begin
      w.opcode = OP_SPARE;
    end
    return w;
  endfunction

  // called at a falling edge; push stays high after acceptance until the next call
  task automatic send_word(input ich_in_t w, input bit fixed, input ich_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_word   <= w;
    drv_fixed <= fixed;
    drv_want  <= want;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // stop sending, wait for every read answer, then let pixel and clear words drain
  task automatic settle(input int extra);
    push <= 1'b0;
    while (read_queue.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    ich_in_t w;
    int      counted;

    wipe_histogram();
    mode_q = 1'b0;
    foreach (hot_bin[i]) hot_bin[i] = '0;

    // directed words: empty store, grey extremes, clear, colour primaries, dropped opcode
    plan = '{
      check_row(rd_bin(CH_LUMA, 8'd0), res(0, 0, 1'b0)),
      check_row(rd_bin(CH_BLU, 8'd255), res(0, 0, 1'b0)),
      word_row(ich_in_t'('1)),
      word_row(px_grey(8'd0)),
      word_row(px_grey(8'd255)),
      word_row(px_grey(8'd255)),
      check_row(rd_bin(CH_LUMA, 8'd255), res(2, 2, 1'b1)),
      check_row(rd_bin(CH_LUMA, 8'd0), res(1, 2, 1'b1)),
      check_row(rd_bin(CH_RED, 8'd255), res(0, 0, 1'b1)),
      word_row(bare(OP_CLEAR)),
      check_row(rd_bin(CH_LUMA, 8'd255), res(0, 0, 1'b0)),
      mode_row(1'b1),
      word_row(px_rgb(8'd255, 8'd255, 8'd255)),
      word_row(px_rgb(8'd0, 8'd0, 8'd0)),
      word_row(px_rgb(8'd255, 8'd0, 8'd0)),
      word_row(px_rgb(8'd0, 8'd255, 8'd0)),
      word_row(px_rgb(8'd0, 8'd0, 8'd255)),
      word_row(rd_bin(CH_LUMA, 8'd255)),
      word_row(rd_bin(CH_RED, 8'd0)),
      word_row(rd_bin(CH_GRN, 8'd255)),
      word_row(rd_bin(CH_BLU, 8'd0)),
      word_row(bare(OP_SPARE)),
      word_row(bare(OP_CLEAR)),
      check_row(rd_bin(CH_GRN, 8'd0), res(0, 0, 1'b0)),
      mode_row(1'b0)
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // mode is taken even while the clearing pass holds full high
    write_mode(1'b0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_MODE) begin
        settle(SETTLE_CYCLES);
        write_mode(plan[i].mode);
      end else begin
        send_word(plan[i].w, plan[i].fixed, plan[i].want);
      end
    end

    // random phases, each under its own idle pattern and color mode
    for (int ph = 0; ph < 4; ph++) begin
      settle(SETTLE_CYCLES);
      send_idle_pct = SEND_IDLE[ph];
      pop_stall_pct = POP_STALL[ph];
      write_mode(PHASE_MODE[ph]);
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        w = next_word();
        if (w.opcode != OP_SPARE) counted++;
        send_word(w, 1'b0, '0);
        // hold off once so the result side runs completely dry
        if (ph == 1 && counted == WORDS_PER_PHASE / 2) settle(0);
      end
    end

    settle(SETTLE_CYCLES);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
